### hdl/rsca_pkg.sv
`default_nettype none

package rsca_pkg;

	localparam int REGION_BITS = 7;
	localparam logic [10:0] REGION_LIMIT_RESET = 11'd1024;
	localparam int ADDR_REGIONS = 1024;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_RESERVE = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [17:0] size_units;
		logic [16:0] address;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [16:0] block_address;
	} rsp_t;

	typedef logic [10:0] cfg_t;

	// Outcome of testing one region mask against the current request.
	typedef struct packed {
		logic       hit;
		logic       region_free;
		logic [7:0] new_mask;
		logic [6:0] offset;
	} eval_t;

	// Mask bit of the size class: 0 for one unit, 2..7 for 2..64 units.
	function automatic logic [2:0] class_bit(input logic [17:0] s);
		logic [2:0] b;
		if (s <= 18'd1)       b = 3'd0;
		else if (s <= 18'd2)  b = 3'd2;
		else if (s <= 18'd4)  b = 3'd3;
		else if (s <= 18'd8)  b = 3'd4;
		else if (s <= 18'd16) b = 3'd5;
		else if (s <= 18'd32) b = 3'd6;
		else                  b = 3'd7;
		return b;
	endfunction

	// Offset of a block within its region, in units.
	function automatic logic [6:0] bit_offset(input logic [2:0] b);
		logic [6:0] o;
		o = 7'd0;
		if (b != 3'd0) o = 7'd1 << (b - 3'd1);
		return o;
	endfunction

endpackage

`default_nettype wire

### hdl/rsca_chan_if.sv
`default_nettype none

interface rsca_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/rsca_region_eval.sv
`default_nettype none

module rsca_region_eval (
	input  logic [7:0]     mask,
	input  logic [2:0]     cls,
	output rsca_pkg::eval_t ev
);
	import rsca_pkg::*;

	logic [2:0] pick;
	logic       hit;

	always_comb begin
		pick = cls;
		hit  = 1'b0;
		if (cls == 3'd0) begin
			// The one-unit class prefers the block at offset zero.
			if (!mask[0]) begin
				pick = 3'd0;
				hit  = 1'b1;
			end else if (!mask[1]) begin
				pick = 3'd1;
				hit  = 1'b1;
			end
		end else begin
			hit = !mask[cls];
		end
	end

	assign ev.hit         = hit;
	assign ev.region_free = (mask == 8'd0);
	assign ev.new_mask    = mask | (8'd1 << pick);
	assign ev.offset      = bit_offset(pick);

endmodule

`default_nettype wire

### hdl/region_size_class_allocator.sv
// Allocate scans the region masks in order (one region mask read per cycle); a claim that
// spans several regions then writes each of its regions in turn. Release and reserve of whole
// regions write each region in turn, a class release reads and then rewrites one region mask;
// requests are taken one at a time.
// After reset the mask memory is cleared region by region, during which no request
// is taken; configuration writes are taken at all times.
`default_nettype none

module region_size_class_allocator #(
	parameter int REGION_COUNT = 1024
) (
	input  wire         clk,
	input  wire         arst_n,
	rsca_chan_if.sink   req,
	rsca_chan_if.source rsp,
	rsca_chan_if.sink   cfg
);
	import rsca_pkg::*;

	localparam int AW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
	localparam int LIM_CAP = (REGION_COUNT < ADDR_REGIONS) ? REGION_COUNT : ADDR_REGIONS;
	localparam logic [10:0] LIM_CAP_W = 11'(LIM_CAP);
	localparam logic [16:0] REGION_COUNT_W = 17'(REGION_COUNT);
	localparam logic [AW-1:0] LAST_REGION = AW'(REGION_COUNT - 1);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_FILL  = 7'b0001000,
		S_RD    = 7'b0010000,
		S_MOD   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t      state_q;
	logic        rsp_valid_q;
	rsp_t        rsp_data_q;
	logic [16:0] wm_q;
	logic [10:0] region_limit_q;
	logic [AW-1:0] clr_q;

	logic        pend_s1;
	logic [10:0] idx_s1;
	logic [10:0] scan_q;
	logic [10:0] start_q;
	logic [11:0] run_q;
	logic [11:0] need_q;
	logic [2:0]  cls_q;
	logic        large_q;
	logic [11:0] fill_idx_q;
	logic [11:0] fill_cnt_q;
	logic [7:0]  fill_val_q;
	logic [2:0]  clrbit_q;
	logic        res_ok_q;
	logic [16:0] res_addr_q;

	logic [7:0] mask_mem [REGION_COUNT];
	logic [7:0] mem_rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;

	eval_t ev;

	req_t        in;
	logic [18:0] need_sum;
	logic [11:0] need_in;
	logic [17:0] wm_sum;
	logic [10:0] r0;
	logic [10:0] lim;
	logic        scan_more;
	logic [2:0]  cls_in;
	logic [9:0]  rel_region;
	logic        rel_in_store;
	logic [16:0] scan_ext;
	logic [16:0] idx_ext;
	logic [16:0] fill_ext;
	logic        fill_in_store;
	logic [16:0] small_addr;
	logic [16:0] large_addr;
	logic        small_hit;
	logic        large_hit;
	logic        scan_fail;
	logic        out_free;

	assign in        = req.data;
	assign need_sum  = {1'b0, in.size_units} + 19'd127;
	assign need_in   = need_sum[18:7];
	assign wm_sum    = {1'b0, wm_q} + 18'd127;
	assign r0        = wm_sum[17:7];
	assign lim       = (region_limit_q < LIM_CAP_W) ? region_limit_q : LIM_CAP_W;
	assign scan_more = (scan_q < lim);
	assign cls_in    = class_bit(in.size_units);
	assign rel_region   = in.address[16:REGION_BITS];
	assign rel_in_store = (17'(rel_region) < REGION_COUNT_W);

	assign scan_ext      = 17'(scan_q);
	assign idx_ext       = 17'(idx_s1);
	assign fill_ext      = 17'(fill_idx_q);
	assign fill_in_store = (fill_ext < REGION_COUNT_W);

	assign small_addr = {idx_s1[9:0], ev.offset};
	assign large_addr = {start_q[9:0], 7'd0};
	assign small_hit  = (state_q == S_SCAN) && pend_s1 && !large_q && ev.hit;
	assign large_hit  = (state_q == S_SCAN) && pend_s1 && large_q && ev.region_free
		&& ((run_q + 12'd1) == need_q);
	assign scan_fail  = (state_q == S_SCAN) && !pend_s1 && !scan_more;
	assign out_free   = !rsp_valid_q || rsp.ready;

	rsca_region_eval u_eval (
		.mask (mem_rdata_q),
		.cls  (cls_q),
		.ev   (ev)
	);

	// Mask memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_ext[AW-1:0];
		mem_wdata = fill_val_q;
		mem_raddr = scan_ext[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 8'd0;
			end
			S_SCAN: begin
				mem_we    = small_hit;
				mem_waddr = idx_ext[AW-1:0];
				mem_wdata = ev.new_mask;
			end
			S_FILL: begin
				mem_we = (fill_cnt_q != 12'd0) && fill_in_store;
			end
			S_RD: begin
				mem_raddr = fill_ext[AW-1:0];
			end
			S_MOD: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata_q & ~(8'd1 << clrbit_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mask_mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mask_mem[mem_raddr];
	end

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			rsp_valid_q    <= 1'b0;
			wm_q           <= 17'd0;
			region_limit_q <= REGION_LIMIT_RESET;
			clr_q          <= '0;
			pend_s1        <= 1'b0;
		end else begin
			if (cfg.valid) region_limit_q <= cfg.data;
			// While a result is loaded the done state sets valid itself.
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) rsp_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_REGION) state_q <= S_IDLE;
				end
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (req.valid) begin
						case (in.req_type)
							REQ_ALLOC: state_q <= S_SCAN;
							REQ_RELEASE: begin
								if (in.address < wm_q) wm_q <= in.address;
								if (in.size_units > 18'd64) state_q <= S_FILL;
								else if (rel_in_store)      state_q <= S_RD;
								else                        state_q <= S_DONE;
							end
							REQ_RESERVE: state_q <= S_FILL;
							default:     state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					pend_s1 <= scan_more;
					if (small_hit) begin
						if (small_addr > wm_q) wm_q <= small_addr;
						state_q <= S_DONE;
					end else if (large_hit) begin
						if (large_addr > wm_q) wm_q <= large_addr;
						state_q <= S_FILL;
					end else if (scan_fail) begin
						state_q <= S_DONE;
					end
				end
				S_FILL: begin
					if (fill_cnt_q == 12'd0) state_q <= S_DONE;
				end
				S_RD:  state_q <= S_MOD;
				S_MOD: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_ok_q   <= 1'b1;
				res_addr_q <= 17'd0;
				cls_q      <= cls_in;
				large_q    <= (in.size_units > 18'd64);
				need_q     <= need_in;
				scan_q     <= r0;
				start_q    <= r0;
				run_q      <= 12'd0;
				fill_idx_q <= 12'(rel_region);
				fill_cnt_q <= need_in;
				fill_val_q <= (in.req_type == REQ_RESERVE) ? 8'hFF : 8'h00;
				// An unaligned one-unit release frees the block at offset one.
				clrbit_q   <= ((cls_in == 3'd0) && (in.address[6:0] != 7'd0)) ? 3'd1 : cls_in;
				if (in.req_type != REQ_ALLOC && in.req_type != REQ_RELEASE
						&& in.req_type != REQ_RESERVE) begin
					res_ok_q <= 1'b0;
				end
			end
			S_SCAN: begin
				if (scan_more) begin
					idx_s1 <= scan_q;
					scan_q <= scan_q + 11'd1;
				end
				if (small_hit) begin
					res_addr_q <= small_addr;
				end else if (large_hit) begin
					res_addr_q <= large_addr;
					fill_idx_q <= 12'(start_q);
					fill_cnt_q <= need_q;
					fill_val_q <= 8'hFF;
				end else if (pend_s1 && large_q) begin
					// A used region breaks the run of free regions.
					if (ev.region_free) begin
						run_q <= run_q + 12'd1;
					end else begin
						run_q   <= 12'd0;
						start_q <= idx_s1 + 11'd1;
					end
				end
				if (scan_fail) res_ok_q <= 1'b0;
			end
			S_FILL: begin
				if (fill_cnt_q != 12'd0) begin
					fill_idx_q <= fill_idx_q + 12'd1;
					fill_cnt_q <= fill_cnt_q - 12'd1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					rsp_data_q.ok            <= res_ok_q;
					rsp_data_q.block_address <= res_addr_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
